/* hdl/sasw_pkg.sv */
// Package for the selective-repeat ARQ sender window.
// Holds widths, codes, the slot memory word and the result item type.
// Used by every other file of the block; depends on nothing.
`default_nettype none
package sasw_pkg;
  localparam int WIN      = 32;
  localparam int IDX_W    = 5;
  localparam int CNT_W    = 6;
  localparam int SEQ_W    = 16;
  localparam int HND_W    = 16;
  localparam int LEN_W    = 11;
  localparam int TIME_W   = 32;
  localparam int RETX_W   = 8;
  localparam int RTO_W    = 16;
  localparam int SACK_W   = 32;
  localparam int APB_AW   = 4;
  localparam logic [RTO_W-1:0] RTO_FLOOR = 16'd50;
  localparam logic [RETX_W-1:0] RETX_MAX = 8'd255;

  // Request codes.
  localparam logic [1:0] REQ_QUEUE = 2'd0;
  localparam logic [1:0] REQ_ACK   = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_QUEUE = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_TX    = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;

  // Queue status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_LARGE = 2'd2;

  // Register byte addresses.
  localparam logic [APB_AW-1:0] ADDR_RTO_INIT = 4'd0;
  localparam logic [APB_AW-1:0] ADDR_RTO_MAX  = 4'd4;
  localparam logic [APB_AW-1:0] ADDR_MAX_LEN  = 4'd8;

  // Register reset values.
  localparam logic [RTO_W-1:0] RST_RTO_INIT = 16'd200;
  localparam logic [RTO_W-1:0] RST_RTO_MAX  = 16'd10000;
  localparam logic [LEN_W-1:0] RST_MAX_LEN  = 11'd1400;

  typedef struct packed {
    logic [HND_W-1:0]  handle;
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] sent_time;
    logic [RETX_W-1:0] retx;
  } slot_word_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [SEQ_W-1:0] seq;
    logic [HND_W-1:0] handle;
    logic [LEN_W-1:0] len;
    logic             retx;
    logic [CNT_W-1:0] avail;
    logic [RTO_W-1:0] rto;
    logic             last;
  } out_item_t;
endpackage
`default_nettype wire

/* hdl/sasw_in_if.sv */
// Input channel of the sender window: valid/ready and the request item.
// Depends on sasw_pkg for field widths.
`default_nettype none
interface sasw_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [sasw_pkg::HND_W-1:0]   payload_handle;
  logic [sasw_pkg::LEN_W-1:0]   payload_len;
  logic [sasw_pkg::SEQ_W-1:0]   ack_seq_in;
  logic [sasw_pkg::SACK_W-1:0]  sack_bitmap;
  logic [sasw_pkg::TIME_W-1:0]  now_ms;
  modport source (output valid, req_type, payload_handle, payload_len, ack_seq_in,
                  sack_bitmap, now_ms, input ready);
  modport sink (input valid, req_type, payload_handle, payload_len, ack_seq_in,
                sack_bitmap, now_ms, output ready);
endinterface
`default_nettype wire

/* hdl/sasw_out_if.sv */
// Result channel of the sender window: valid/ready and the result item.
// Depends on sasw_pkg for field widths.
`default_nettype none
interface sasw_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  resp_kind;
  logic [1:0]                  status;
  logic [sasw_pkg::SEQ_W-1:0]  tx_seq;
  logic [sasw_pkg::HND_W-1:0]  tx_handle;
  logic [sasw_pkg::LEN_W-1:0]  tx_len;
  logic                        tx_is_retransmit;
  logic [sasw_pkg::CNT_W-1:0]  window_avail;
  logic [sasw_pkg::RTO_W-1:0]  rto_now;
  logic                        last;
  modport source (output valid, resp_kind, status, tx_seq, tx_handle, tx_len,
                  tx_is_retransmit, window_avail, rto_now, last, input ready);
  modport sink (input valid, resp_kind, status, tx_seq, tx_handle, tx_len,
                tx_is_retransmit, window_avail, rto_now, last, output ready);
endinterface
`default_nettype wire

/* hdl/sack_arq_sender_window.sv */
// Selective-repeat ARQ sender window with SACK and a Jacobson RTO.
// A queue request is answered directly from idle. An ACK walks the base over
// the slots it covers, reading each slot and marking it acknowledged, and runs
// the RTT steps for each sample; it then walks the SACK map one bit a cycle
// and ends with its done item. A tick walks the slots in the window, skipping
// acknowledged ones and reading the others, and ends with its done item.
// Both walks use the single read port of the slot memory; a tick writes a slot
// back when it sends it, and tick sends and done items wait while the result
// channel stalls. One item is in work at a time. There is no clearing pass:
// sent and acknowledged flags are flip-flops cleared by reset.
// Depends on sasw_pkg, sasw_in_if, sasw_out_if, sasw_slot_ram and sasw_rtt.
`default_nettype none
module sack_arq_sender_window (
  input  wire                              clk,
  input  wire                              rst_n,
  sasw_in_if.sink                          in_ch,
  sasw_out_if.source                       out_ch,
  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire [sasw_pkg::APB_AW-1:0]       cfg_paddr,
  input  wire [31:0]                       cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ACK_RD  = 4'd1;
  localparam logic [3:0] S_ACK_EV  = 4'd2;
  localparam logic [3:0] S_RTT_A   = 4'd3;
  localparam logic [3:0] S_RTT_B   = 4'd4;
  localparam logic [3:0] S_SACK    = 4'd5;
  localparam logic [3:0] S_TICK_RD = 4'd6;
  localparam logic [3:0] S_TICK_EV = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  localparam logic [sasw_pkg::CNT_W-1:0] WIN_C = sasw_pkg::CNT_W'(sasw_pkg::WIN);

  // Configuration registers.
  logic [sasw_pkg::RTO_W-1:0] rto_init_r, rto_max_r;
  logic [sasw_pkg::LEN_W-1:0] max_len_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rto_init_r <= sasw_pkg::RST_RTO_INIT;
      rto_max_r  <= sasw_pkg::RST_RTO_MAX;
      max_len_r  <= sasw_pkg::RST_MAX_LEN;
    end else if (cfg_wr) begin
      case (cfg_paddr)
        sasw_pkg::ADDR_RTO_INIT: rto_init_r <= cfg_pwdata[sasw_pkg::RTO_W-1:0];
        sasw_pkg::ADDR_RTO_MAX:  rto_max_r  <= cfg_pwdata[sasw_pkg::RTO_W-1:0];
        sasw_pkg::ADDR_MAX_LEN:  max_len_r  <= cfg_pwdata[sasw_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      sasw_pkg::ADDR_RTO_INIT: cfg_prdata = {16'd0, rto_init_r};
      sasw_pkg::ADDR_RTO_MAX:  cfg_prdata = {16'd0, rto_max_r};
      sasw_pkg::ADDR_MAX_LEN:  cfg_prdata = {21'd0, max_len_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  // Control state and window registers.
  logic [3:0]                   state_r, state_nxt;
  logic [sasw_pkg::SEQ_W-1:0]   next_r, next_nxt, base_r, base_nxt;
  logic [sasw_pkg::CNT_W-1:0]   infl_r, infl_nxt;
  logic [sasw_pkg::RTO_W-1:0]   rto_r, rto_nxt;
  logic [sasw_pkg::WIN-1:0]     sent_r, sent_nxt, acked_r, acked_nxt;
  logic [sasw_pkg::CNT_W-1:0]   cnt_r, cnt_nxt, lim_r, lim_nxt;
  logic [1:0]                   kind_r, kind_nxt;
  logic                         ov_r, ov_nxt;
  sasw_pkg::out_item_t          oitem_r, oitem_nxt;

  // Latched request item.
  logic [sasw_pkg::SEQ_W-1:0]   ack_r, ack_nxt;
  logic [sasw_pkg::SACK_W-1:0]  sack_r, sack_nxt;
  logic [sasw_pkg::TIME_W-1:0]  now_r, now_nxt;
  logic [sasw_pkg::TIME_W-1:0]  rtt_r, rtt_nxt;

  // Slot memory and RTT unit.
  logic                         ram_we, ram_re;
  logic [sasw_pkg::IDX_W-1:0]   ram_waddr, ram_raddr;
  sasw_pkg::slot_word_t         ram_wdata, ram_rdata;
  logic                         rtt_a;
  logic [sasw_pkg::RTO_W-1:0]   rtt_rto;

  sasw_slot_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sasw_rtt u_rtt (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_a  (rtt_a),
    .rtt     (rtt_r),
    .rto_max (rto_max_r),
    .rto     (rtt_rto)
  );

  // Helpers for the main sequencer.
  logic                         out_free, in_acc;
  logic [sasw_pkg::SEQ_W-1:0]   span, d_ack_next, d_ack_base, seq_i, s_sack;
  logic [sasw_pkg::SEQ_W-1:0]   d_s_base, d_s_next, ack_cl;
  logic [sasw_pkg::IDX_W-1:0]   idx_b, idx_i, idx_s;
  logic                         ack_more;
  logic [sasw_pkg::TIME_W-1:0]  elapsed;
  logic                         timeout;
  logic [sasw_pkg::RTO_W:0]     rto2;
  logic [sasw_pkg::RTO_W-1:0]   rto_dbl;
  logic [sasw_pkg::CNT_W-1:0]   avail;
  logic [sasw_pkg::IDX_W-1:0]   bit_i;

  assign out_free    = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    span       = next_r - base_r;
    d_ack_next = in_ch.ack_seq_in - next_r;
    ack_cl     = (!d_ack_next[15] && d_ack_next != '0) ? next_r : in_ch.ack_seq_in;
    d_ack_base = ack_r - base_r;
    ack_more   = !d_ack_base[15] && d_ack_base != '0 && cnt_r < WIN_C;
    idx_b      = base_r[sasw_pkg::IDX_W-1:0];
    seq_i      = base_r + {10'd0, cnt_r};
    idx_i      = seq_i[sasw_pkg::IDX_W-1:0];
    bit_i      = cnt_r[sasw_pkg::IDX_W-1:0];
    s_sack     = ack_r + 16'd1 + {11'd0, bit_i};
    idx_s      = s_sack[sasw_pkg::IDX_W-1:0];
    d_s_base   = s_sack - base_r;
    d_s_next   = s_sack - next_r;
    elapsed    = now_r - ram_rdata.sent_time;
    timeout    = !elapsed[31] && elapsed >= {16'd0, rto_r};
    rto2       = {rto_r, 1'b0};
    rto_dbl    = (rto2 > {1'b0, rto_max_r}) ? rto_max_r : rto2[sasw_pkg::RTO_W-1:0];
  end

  // Main sequencer.
  always_comb begin
    state_nxt = state_r;
    next_nxt  = next_r;
    base_nxt  = base_r;
    infl_nxt  = infl_r;
    rto_nxt   = rto_r;
    sent_nxt  = sent_r;
    acked_nxt = acked_r;
    cnt_nxt   = cnt_r;
    lim_nxt   = lim_r;
    kind_nxt  = kind_r;
    ack_nxt   = ack_r;
    sack_nxt  = sack_r;
    now_nxt   = now_r;
    rtt_nxt   = rtt_r;
    ov_nxt    = ov_r && !out_ch.ready;
    oitem_nxt = oitem_r;
    ram_we    = 1'b0;
    ram_waddr = next_r[sasw_pkg::IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx_b;
    rtt_a     = 1'b0;
    avail     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          now_nxt = in_ch.now_ms;
          cnt_nxt = '0;
          case (in_ch.req_type)
            sasw_pkg::REQ_QUEUE: begin
              oitem_nxt = '0;
              oitem_nxt.kind = sasw_pkg::KIND_QUEUE;
              oitem_nxt.last = 1'b1;
              if (infl_r >= WIN_C || span >= 16'(sasw_pkg::WIN)) begin
                oitem_nxt.status = sasw_pkg::ST_FULL;
              end else if (in_ch.payload_len > max_len_r) begin
                oitem_nxt.status = sasw_pkg::ST_LARGE;
              end else begin
                oitem_nxt.status = sasw_pkg::ST_OK;
                ram_we = 1'b1;
                ram_wdata.handle    = in_ch.payload_handle;
                ram_wdata.len       = in_ch.payload_len;
                ram_wdata.sent_time = '0;
                ram_wdata.retx      = '0;
                sent_nxt[next_r[sasw_pkg::IDX_W-1:0]]  = 1'b0;
                acked_nxt[next_r[sasw_pkg::IDX_W-1:0]] = 1'b0;
                next_nxt = next_r + 16'd1;
                infl_nxt = infl_r + 6'd1;
              end
              avail = WIN_C - infl_nxt;
              oitem_nxt.avail = avail;
              oitem_nxt.rto   = rto_r;
              ov_nxt = 1'b1;
            end
            sasw_pkg::REQ_ACK: begin
              ack_nxt   = ack_cl;
              sack_nxt  = in_ch.sack_bitmap;
              kind_nxt  = sasw_pkg::KIND_ACK;
              state_nxt = S_ACK_RD;
            end
            sasw_pkg::REQ_TICK: begin
              lim_nxt   = (span >= 16'(sasw_pkg::WIN)) ? WIN_C : span[sasw_pkg::CNT_W-1:0];
              kind_nxt  = sasw_pkg::KIND_TICK;
              state_nxt = S_TICK_RD;
            end
            default: ;
          endcase
        end
      end

      // Cumulative walk: read the slot at the base.
      S_ACK_RD: begin
        if (ack_more) begin
          ram_re    = 1'b1;
          state_nxt = S_ACK_EV;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_SACK;
        end
      end

      S_ACK_EV: begin
        state_nxt = S_ACK_RD;
        if (!acked_r[idx_b]) begin
          if (sent_r[idx_b] && ram_rdata.retx == '0) begin
            rtt_nxt   = now_r - ram_rdata.sent_time;
            state_nxt = S_RTT_A;
          end
          acked_nxt[idx_b] = 1'b1;
          if (infl_r != '0) begin
            infl_nxt = infl_r - 6'd1;
          end
        end
        base_nxt = base_r + 16'd1;
        cnt_nxt  = cnt_r + 6'd1;
      end

      S_RTT_A: begin
        rtt_a     = 1'b1;
        state_nxt = S_RTT_B;
      end

      S_RTT_B: begin
        rto_nxt   = rtt_rto;
        state_nxt = S_ACK_RD;
      end

      // Selective acknowledgements, one map bit a cycle.
      S_SACK: begin
        if (sack_r[bit_i] && !d_s_base[15] && d_s_base[15:5] == '0 && d_s_next[15]) begin
          if (!acked_r[idx_s]) begin
            acked_nxt[idx_s] = 1'b1;
            if (infl_r != '0) begin
              infl_nxt = infl_r - 6'd1;
            end
          end
        end
        cnt_nxt = cnt_r + 6'd1;
        if (bit_i == 5'd31) begin
          state_nxt = S_DONE;
        end
      end

      // Tick walk: skip acknowledged slots, read the others.
      S_TICK_RD: begin
        if (cnt_r >= lim_r) begin
          state_nxt = S_DONE;
        end else if (acked_r[idx_i]) begin
          cnt_nxt = cnt_r + 6'd1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_i;
          state_nxt = S_TICK_EV;
        end
      end

      S_TICK_EV: begin
        ram_waddr = idx_i;
        if (!sent_r[idx_i] || timeout) begin
          if (out_free) begin
            oitem_nxt        = '0;
            oitem_nxt.kind   = sasw_pkg::KIND_TX;
            oitem_nxt.seq    = seq_i;
            oitem_nxt.handle = ram_rdata.handle;
            oitem_nxt.len    = ram_rdata.len;
            oitem_nxt.avail  = WIN_C - infl_r;
            ram_we = 1'b1;
            ram_wdata.sent_time = now_r;
            if (!sent_r[idx_i]) begin
              sent_nxt[idx_i] = 1'b1;
              ram_wdata.retx  = '0;
              oitem_nxt.rto   = rto_r;
            end else begin
              if (ram_rdata.retx != sasw_pkg::RETX_MAX) begin
                ram_wdata.retx = ram_rdata.retx + 8'd1;
              end
              rto_nxt        = rto_dbl;
              oitem_nxt.retx = 1'b1;
              oitem_nxt.rto  = rto_dbl;
            end
            ov_nxt    = 1'b1;
            cnt_nxt   = cnt_r + 6'd1;
            state_nxt = S_TICK_RD;
          end
        end else begin
          cnt_nxt   = cnt_r + 6'd1;
          state_nxt = S_TICK_RD;
        end
      end

      // Done item of an ACK or a tick.
      S_DONE: begin
        if (out_free) begin
          oitem_nxt       = '0;
          oitem_nxt.kind  = kind_r;
          oitem_nxt.avail = WIN_C - infl_r;
          oitem_nxt.rto   = rto_r;
          oitem_nxt.last  = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      next_r  <= '0;
      base_r  <= '0;
      infl_r  <= '0;
      rto_r   <= sasw_pkg::RST_RTO_INIT;
      sent_r  <= '0;
      acked_r <= '0;
      cnt_r   <= '0;
      lim_r   <= '0;
      kind_r  <= sasw_pkg::KIND_ACK;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      next_r  <= next_nxt;
      base_r  <= base_nxt;
      infl_r  <= infl_nxt;
      rto_r   <= rto_nxt;
      sent_r  <= sent_nxt;
      acked_r <= acked_nxt;
      cnt_r   <= cnt_nxt;
      lim_r   <= lim_nxt;
      kind_r  <= kind_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ack_r   <= ack_nxt;
    sack_r  <= sack_nxt;
    now_r   <= now_nxt;
    rtt_r   <= rtt_nxt;
    oitem_r <= oitem_nxt;
  end

  // Result channel.
  assign out_ch.valid            = ov_r;
  assign out_ch.resp_kind        = oitem_r.kind;
  assign out_ch.status           = oitem_r.status;
  assign out_ch.tx_seq           = oitem_r.seq;
  assign out_ch.tx_handle        = oitem_r.handle;
  assign out_ch.tx_len           = oitem_r.len;
  assign out_ch.tx_is_retransmit = oitem_r.retx;
  assign out_ch.window_avail     = oitem_r.avail;
  assign out_ch.rto_now          = oitem_r.rto;
  assign out_ch.last             = oitem_r.last;
endmodule
`default_nettype wire

/* hdl/sasw_slot_ram.sv */
// Slot memory: one write port and one registered read port.
// Holds handle, length, send time and retry count per ring slot; uses sasw_pkg.
`default_nettype none
module sasw_slot_ram (
  input  wire                          clk,
  input  wire                          we,
  input  wire [sasw_pkg::IDX_W-1:0]    waddr,
  input  wire sasw_pkg::slot_word_t    wdata,
  input  wire                          re,
  input  wire [sasw_pkg::IDX_W-1:0]    raddr,
  output sasw_pkg::slot_word_t         rdata
);
  sasw_pkg::slot_word_t mem [sasw_pkg::WIN];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds when no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* hdl/sasw_rtt.sv */
// Jacobson RTT estimator: smoothed RTT, variance and the clamped RTO.
// Each sample registers the estimate, then forms the RTO from it; uses sasw_pkg.
`default_nettype none
module sasw_rtt (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          step_a,
  input  wire [sasw_pkg::TIME_W-1:0]   rtt,
  input  wire [sasw_pkg::RTO_W-1:0]    rto_max,
  output logic [sasw_pkg::RTO_W-1:0]   rto
);
  logic [sasw_pkg::TIME_W-1:0] srtt_r, srtt_nxt;
  logic [sasw_pkg::TIME_W-1:0] var_r, var_nxt;
  logic [sasw_pkg::TIME_W-1:0] dev;
  logic [sasw_pkg::TIME_W+1:0] var_sum;
  logic [sasw_pkg::TIME_W+2:0] srtt_sum;
  logic [sasw_pkg::TIME_W+2:0] rto_sum;

  // First step: new variance and smoothed RTT.
  always_comb begin
    dev      = (srtt_r > rtt) ? srtt_r - rtt : rtt - srtt_r;
    var_sum  = {2'b00, var_r} + {1'b0, var_r, 1'b0} + {2'b00, dev};
    srtt_sum = {srtt_r, 3'b000} - {3'b000, srtt_r} + {3'b000, rtt};
    srtt_nxt = srtt_r;
    var_nxt  = var_r;
    if (step_a) begin
      if (srtt_r == '0) begin
        srtt_nxt = rtt;
        var_nxt  = {1'b0, rtt[sasw_pkg::TIME_W-1:1]};
      end else begin
        var_nxt  = var_sum[sasw_pkg::TIME_W+1:2];
        srtt_nxt = srtt_sum[sasw_pkg::TIME_W+2:3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srtt_r <= '0;
      var_r  <= '0;
    end else begin
      srtt_r <= srtt_nxt;
      var_r  <= var_nxt;
    end
  end

  // Second step: RTO from the new estimate, raised to the floor, then clamped.
  // The sum of srtt and four times the variance needs 35 bits.
  always_comb begin
    rto_sum = {3'b000, srtt_r} + {1'b0, var_r, 2'b00};
    if (rto_sum < {19'd0, sasw_pkg::RTO_FLOOR}) begin
      rto_sum = {19'd0, sasw_pkg::RTO_FLOOR};
    end
    if (rto_sum > {19'd0, rto_max}) begin
      rto_sum = {19'd0, rto_max};
    end
    rto = rto_sum[sasw_pkg::RTO_W-1:0];
  end
endmodule
`default_nettype wire
